FILE: sv/protein_parsimony_combine_core_defines.svh
// Assertion macros shared by the parsimony combine RTL.
// Users must have i_clk and i_rst_n in scope; no other dependencies.
`ifndef PROTEIN_PARSIMONY_COMBINE_CORE_DEFINES_SVH
`define PROTEIN_PARSIMONY_COMBINE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PPC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ppc_pkg.sv
// Shared widths, codes and control types of the parsimony combine block.
// No dependencies.
`timescale 1ns / 1ps

package ppc_pkg;

    localparam int unsigned IN_SET_W      = 24;
    localparam int unsigned SET_WIDTH_DEF = 24;
    localparam int unsigned WEIGHT_W      = 16;
    localparam int unsigned COST_W        = 18;
    localparam int unsigned TOTAL_W       = 40;
    localparam int unsigned TBL_IDX_W     = 8;
    localparam int unsigned TBL_DEPTH     = 256;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_COMBINE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        TBL_LOW  = 2'd0,
        TBL_MID  = 2'd1,
        TBL_HIGH = 2'd2
    } t_tbl_sel;

    // Write and read strobes for the neighbor tables.
    typedef struct packed {
        logic                 we;
        t_tbl_sel             sel;
        logic [TBL_IDX_W-1:0] idx;
        logic                 re_a;
        logic                 re_b;
    } t_tbl_ctrl;

endpackage

FILE: sv/ppc_stream_if.sv
// Valid/ready stream interfaces for input items and result items.
// Depends on ppc_pkg for field widths.
`timescale 1ns / 1ps

interface ppc_in_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic [1:0]                       table_select;
    logic [ppc_pkg::TBL_IDX_W-1:0]    table_index;
    logic [ppc_pkg::IN_SET_W-1:0]     table_word;
    logic [ppc_pkg::IN_SET_W-1:0]     left_set0;
    logic [ppc_pkg::IN_SET_W-1:0]     left_set1;
    logic [ppc_pkg::IN_SET_W-1:0]     left_set2;
    logic [ppc_pkg::IN_SET_W-1:0]     right_set0;
    logic [ppc_pkg::IN_SET_W-1:0]     right_set1;
    logic [ppc_pkg::IN_SET_W-1:0]     right_set2;
    logic [ppc_pkg::WEIGHT_W-1:0]     weight;
    logic                             last;

    modport source (
        output valid, operation, table_select, table_index, table_word,
               left_set0, left_set1, left_set2, right_set0, right_set1, right_set2,
               weight, last,
        input  ready
    );
    modport sink (
        input  valid, operation, table_select, table_index, table_word,
               left_set0, left_set1, left_set2, right_set0, right_set1, right_set2,
               weight, last,
        output ready
    );
endinterface

interface ppc_out_if;
    logic                             valid;
    logic                             ready;
    logic [ppc_pkg::IN_SET_W-1:0]     out_set0;
    logic [ppc_pkg::IN_SET_W-1:0]     out_set1;
    logic [ppc_pkg::IN_SET_W-1:0]     out_set2;
    logic [ppc_pkg::COST_W-1:0]       position_cost;
    logic [ppc_pkg::TOTAL_W-1:0]      total_cost;
    logic                             last_out;

    modport source (
        output valid, out_set0, out_set1, out_set2, position_cost, total_cost, last_out,
        input  ready
    );
    modport sink (
        input  valid, out_set0, out_set1, out_set2, position_cost, total_cost, last_out,
        output ready
    );
endinterface

FILE: sv/ppc_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ppc_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // A read in the same cycle as a write to that entry returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: sv/ppc_nbr_tables.sv
// Three neighbor tables, one per set byte, and the OR that widens a set.
// Depends on ppc_pkg and ppc_ram.
`timescale 1ns / 1ps

module ppc_nbr_tables #(
    parameter int unsigned SET_WIDTH = ppc_pkg::SET_WIDTH_DEF
) (
    input  logic               i_clk,
    input  ppc_pkg::t_tbl_ctrl i_ctrl,
    input  logic [SET_WIDTH-1:0] i_wdata,
    input  logic [SET_WIDTH-1:0] i_set_a,
    input  logic [SET_WIDTH-1:0] i_set_b,
    output logic [SET_WIDTH-1:0] o_widen_a,
    output logic [SET_WIDTH-1:0] o_widen_b
);

    import ppc_pkg::*;

    logic [IN_SET_W-1:0]  ext_a;
    logic [IN_SET_W-1:0]  ext_b;
    logic                 we_low;
    logic                 we_mid;
    logic                 we_high;
    logic [SET_WIDTH-1:0] rd_low_a;
    logic [SET_WIDTH-1:0] rd_low_b;
    logic [SET_WIDTH-1:0] rd_mid_a;
    logic [SET_WIDTH-1:0] rd_mid_b;
    logic [SET_WIDTH-1:0] rd_high_a;
    logic [SET_WIDTH-1:0] rd_high_b;

    // Bytes above the set width index with zero.
    assign ext_a = IN_SET_W'(i_set_a);
    assign ext_b = IN_SET_W'(i_set_b);

    always_comb begin
        we_low  = 1'b0;
        we_mid  = 1'b0;
        we_high = 1'b0;
        case (i_ctrl.sel)
            TBL_LOW:  we_low  = i_ctrl.we;
            TBL_MID:  we_mid  = i_ctrl.we;
            TBL_HIGH: we_high = i_ctrl.we;
            default: begin
                // The unused select code writes nothing.
            end
        endcase
    end

    ppc_ram #(.WIDTH(SET_WIDTH), .DEPTH(TBL_DEPTH)) u_ram_low (
        .i_clk    (i_clk),
        .i_we     (we_low),
        .i_waddr  (i_ctrl.idx),
        .i_wdata  (i_wdata),
        .i_re_a   (i_ctrl.re_a),
        .i_raddr_a(ext_a[7:0]),
        .o_rdata_a(rd_low_a),
        .i_re_b   (i_ctrl.re_b),
        .i_raddr_b(ext_b[7:0]),
        .o_rdata_b(rd_low_b)
    );

    ppc_ram #(.WIDTH(SET_WIDTH), .DEPTH(TBL_DEPTH)) u_ram_mid (
        .i_clk    (i_clk),
        .i_we     (we_mid),
        .i_waddr  (i_ctrl.idx),
        .i_wdata  (i_wdata),
        .i_re_a   (i_ctrl.re_a),
        .i_raddr_a(ext_a[15:8]),
        .o_rdata_a(rd_mid_a),
        .i_re_b   (i_ctrl.re_b),
        .i_raddr_b(ext_b[15:8]),
        .o_rdata_b(rd_mid_b)
    );

    ppc_ram #(.WIDTH(SET_WIDTH), .DEPTH(TBL_DEPTH)) u_ram_high (
        .i_clk    (i_clk),
        .i_we     (we_high),
        .i_waddr  (i_ctrl.idx),
        .i_wdata  (i_wdata),
        .i_re_a   (i_ctrl.re_a),
        .i_raddr_a(ext_a[23:16]),
        .o_rdata_a(rd_high_a),
        .i_re_b   (i_ctrl.re_b),
        .i_raddr_b(ext_b[23:16]),
        .o_rdata_b(rd_high_b)
    );

    assign o_widen_a = rd_low_a | rd_mid_a | rd_high_a;
    assign o_widen_b = rd_low_b | rd_mid_b | rd_high_b;

endmodule

FILE: sv/ppc_cost_acc.sv
// Saturating running total of position costs, cleared after the last position.
// Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_cost_acc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_add_en,
    input  logic [ppc_pkg::COST_W-1:0]  i_pos_cost,
    input  logic                        i_last,
    output logic [ppc_pkg::TOTAL_W-1:0] o_total
);

    import ppc_pkg::*;

    logic [TOTAL_W-1:0] r_sum;
    logic [TOTAL_W-1:0] n_sum;
    logic [TOTAL_W:0]   sum_wide;
    logic [TOTAL_W-1:0] sum_sat;

    assign sum_wide = {1'b0, r_sum} + (TOTAL_W + 1)'(i_pos_cost);
    assign sum_sat  = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];
    assign o_total  = sum_sat;

    always_comb begin
        n_sum = r_sum;
        if (i_add_en) begin
            n_sum = i_last ? '0 : sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

endmodule

FILE: sv/protein_parsimony_combine_core.sv
// Parsimony combine core: merges two child set triples per position into a parent triple.
// A result passes stages r1, r2 and r3; one item per cycle unless o_out.ready stalls.
// The two dependent neighbor lookups use the two read ports of each table RAM.
// A table load yields no result; a later combine sees the new entry.
// Reset clears the pipeline valid bits and the total; table contents are not cleared.
`timescale 1ns / 1ps
`include "protein_parsimony_combine_core_defines.svh"

module protein_parsimony_combine_core #(
    parameter int unsigned SET_WIDTH = ppc_pkg::SET_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ppc_in_if.sink     i_in,
    ppc_out_if.source  o_out
);

    import ppc_pkg::*;

    typedef logic [SET_WIDTH-1:0] t_set;

    typedef enum logic [1:0] {
        CASE_ZERO  = 2'd0,
        CASE_ONE   = 2'd1,
        CASE_TWO   = 2'd2,
        CASE_THREE = 2'd3
    } t_case;

    logic en1;
    logic en2;
    logic en3;
    logic in_take;
    logic is_comb;

    t_set l0, l1, l2, r0, r1, r2;
    t_set d11, d22, uni, xover;
    t_set a0, a1, a2, a3, a4, a5;
    t_set q0, q1, q2;
    t_case sel_case;
    logic [COST_W-1:0] w_ext;
    logic [COST_W-1:0] pos_cost;

    t_tbl_ctrl tbl_ctrl;
    t_set      widen_a;
    t_set      widen_b;
    t_set      n_p1_wide;
    t_set      n_p2_wide;
    logic [TOTAL_W-1:0] n_total;

    logic              r_v1, r_v2, r_v3;
    t_set              r1_p0, r1_p1, r1_p2;
    logic [COST_W-1:0] r1_pc;
    logic              r1_last;
    t_set              r2_p0, r2_p1, r2_p2;
    logic [COST_W-1:0] r2_pc;
    logic              r2_last;
    t_set              r3_p0, r3_p1, r3_p2;
    logic [COST_W-1:0] r3_pc;
    logic [TOTAL_W-1:0] r3_total;
    logic              r3_last;

    // Each stage moves when it is empty or the stage after it moves.
    assign en3 = !r_v3 || o_out.ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_in.ready = en1;
    assign in_take    = i_in.valid && en1;
    assign is_comb    = in_take && (t_op'(i_in.operation) == OP_COMBINE);

    // Case selection on the incoming position.
    always_comb begin
        l0 = i_in.left_set0[SET_WIDTH-1:0];
        l1 = i_in.left_set1[SET_WIDTH-1:0];
        l2 = i_in.left_set2[SET_WIDTH-1:0];
        r0 = i_in.right_set0[SET_WIDTH-1:0];
        r1 = i_in.right_set1[SET_WIDTH-1:0];
        r2 = i_in.right_set2[SET_WIDTH-1:0];

        d11   = l1 & r1;
        d22   = l2 & r2;
        uni   = l0 | r0;
        xover = (r1 & l2) | (r2 & l1);

        a0 = l0 & r0;
        a1 = uni & d11;
        a2 = (uni & d22) | d11;
        a3 = uni | xover;
        a4 = l1 | r1 | d22;
        a5 = l2 | r2;

        if (a0 != '0) begin
            sel_case = CASE_ZERO;
            q0 = a0;
            q1 = a1;
            q2 = a2;
        end else if (a1 != '0) begin
            sel_case = CASE_ONE;
            q0 = a1;
            q1 = a2;
            q2 = a3;
        end else if (a2 != '0) begin
            sel_case = CASE_TWO;
            q0 = a2;
            q1 = a3;
            q2 = a4;
        end else begin
            sel_case = CASE_THREE;
            q0 = a3;
            q1 = a4;
            q2 = a5;
        end
    end

    assign w_ext = COST_W'(i_in.weight);

    always_comb begin
        case (sel_case)
            CASE_ZERO:  pos_cost = '0;
            CASE_ONE:   pos_cost = w_ext;
            CASE_TWO:   pos_cost = w_ext << 1;
            CASE_THREE: pos_cost = w_ext + (w_ext << 1);
            default:    pos_cost = '0;
        endcase
    end

    // Read port A carries the first lookup, port B the second.
    always_comb begin
        tbl_ctrl.we   = in_take && (t_op'(i_in.operation) == OP_LOAD);
        tbl_ctrl.sel  = t_tbl_sel'(i_in.table_select);
        tbl_ctrl.idx  = i_in.table_index;
        tbl_ctrl.re_a = en1;
        tbl_ctrl.re_b = en2;
    end

    assign n_p1_wide = r1_p1 | widen_a;
    assign n_p2_wide = r2_p2 | widen_b;

    ppc_nbr_tables #(.SET_WIDTH(SET_WIDTH)) u_tables (
        .i_clk    (i_clk),
        .i_ctrl   (tbl_ctrl),
        .i_wdata  (i_in.table_word[SET_WIDTH-1:0]),
        .i_set_a  (q0),
        .i_set_b  (n_p1_wide),
        .o_widen_a(widen_a),
        .o_widen_b(widen_b)
    );

    ppc_cost_acc u_cost (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_add_en  (en3 && r_v2),
        .i_pos_cost(r2_pc),
        .i_last    (r2_last),
        .o_total   (n_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= is_comb;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_p0   <= q0;
            r1_p1   <= q1;
            r1_p2   <= q2;
            r1_pc   <= pos_cost;
            r1_last <= i_in.last;
        end
        if (en2) begin
            r2_p0   <= r1_p0;
            r2_p1   <= n_p1_wide;
            r2_p2   <= r1_p2;
            r2_pc   <= r1_pc;
            r2_last <= r1_last;
        end
        if (en3) begin
            r3_p0    <= r2_p0;
            r3_p1    <= r2_p1;
            r3_p2    <= n_p2_wide;
            r3_pc    <= r2_pc;
            r3_total <= n_total;
            r3_last  <= r2_last;
        end
    end

    assign o_out.valid         = r_v3;
    assign o_out.out_set0      = IN_SET_W'(r3_p0);
    assign o_out.out_set1      = IN_SET_W'(r3_p1);
    assign o_out.out_set2      = IN_SET_W'(r3_p2);
    assign o_out.position_cost = r3_pc;
    assign o_out.total_cost    = r3_total;
    assign o_out.last_out      = r3_last;

    `PPC_ASSERT_IMPL(a_stall_only_when_full, !i_in.ready, r_v1 && r_v2 && r_v3,
                     "input stalled with a free stage")
    `PPC_ASSERT_IMPL(a_total_covers_cost, r_v3, r3_total >= TOTAL_W'(r3_pc),
                     "total below the position cost")
    `PPC_ASSERT_NEXT(a_stage_advance, r_v1 && en2, r_v2,
                     "position lost between lookup stages")

endmodule
